@@ sv/ald_pkg.sv @@
`timescale 1ns / 1ps
package ald_pkg;

  // default geometry and weight precision
  localparam int FB_WIDTH_DEF  = 256;
  localparam int FB_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF = 8;

  localparam int COORD_W = 8;
  localparam int COLOR_W = 24;
  localparam int COUNT_W = 10;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PWR,
    ST_PRD,
    ST_SETUP,
    ST_DIV,
    ST_RDA,
    ST_WRA,
    ST_WRB,
    ST_DONE
  } state_t;

endpackage

@@ sv/ald_if.sv @@
`timescale 1ns / 1ps
interface ald_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [ald_pkg::COORD_W-1:0]   x_start;
  logic [ald_pkg::COORD_W-1:0]   y_start;
  logic [ald_pkg::COORD_W-1:0]   x_end;
  logic [ald_pkg::COORD_W-1:0]   y_end;
  logic [ald_pkg::COLOR_W-1:0]   pixel_value;
  modport source (output valid, command, x_start, y_start, x_end, y_end, pixel_value,
                  input ready);
  modport sink (input valid, command, x_start, y_start, x_end, y_end, pixel_value,
                output ready);
endinterface

interface ald_out_if;
  logic                          valid;
  logic                          ready;
  logic [ald_pkg::COLOR_W-1:0]   read_color;
  logic [ald_pkg::COUNT_W-1:0]   pixels_written;
  modport source (output valid, read_color, pixels_written, input ready);
  modport sink (input valid, read_color, pixels_written, output ready);
endinterface

interface ald_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ald_pkg::COLOR_W-1:0]   line_color;
  modport source (output valid, line_color, input ready);
  modport sink (input valid, line_color, output ready);
endinterface

@@ sv/ald_div.sv @@
`timescale 1ns / 1ps
module ald_div #(
  parameter int DVW = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [7:0]     divisor,
  output logic           done,
  output logic [DVW-1:0] quot,
  output logic [7:0]     rem
);
  localparam int CW = $clog2(DVW + 1);

  logic [DVW-1:0] acc_r;
  logic [7:0]     rem_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [8:0]     trial;
  logic           qbit;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial = {rem_r, acc_r[DVW-1]};
    qbit  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DVW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      acc_r <= {acc_r[DVW-2:0], qbit};
      rem_r <= qbit ? 8'(trial - {1'b0, divisor}) : trial[7:0];
    end
  end

  assign done = done_r;
  assign quot = acc_r;
  assign rem  = rem_r;

endmodule

@@ sv/antialiased_line_drawer_top.sv @@
`timescale 1ns / 1ps
// Antialiased line drawer over an RGB frame store (R 23:16, G 15:8, B 7:0).
// Channels: in_ch takes one command word (draw line, write pixel, read pixel),
// out_ch returns exactly one result word per command, cfg_ch sets the line
// color and is always ready; write it only while no command is in flight.
// After reset the block sweeps the store to black, one pixel per cycle, and
// in_ch.ready stays low during the sweep.
// Per step the single store read port and write port do two read-modify-write
// passes; the one-time step divide runs a bit a cycle.
// One command is worked at a time. A finished result sits in the output
// register; the next command is accepted while it waits, but its own result
// is held back until the receiver takes the earlier one.
module antialiased_line_drawer_top #(
  parameter int FB_WIDTH  = ald_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = ald_pkg::FB_HEIGHT_DEF,
  parameter int FRAC_BITS = ald_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ald_in_if.sink    in_ch,
  ald_out_if.source out_ch,
  ald_cfg_if.sink   cfg_ch
);
  import ald_pkg::*;

  localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = COORD_W + FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // frame store
  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdata_r;
  logic               rd_en, we;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [COLOR_W-1:0] wdata;

  state_t state_r, state_nxt;

  logic [COLOR_W-1:0] line_color_r;
  logic [1:0]         cmd_r;
  logic [7:0]         xs_r, ys_r, xe_r, ye_r;
  logic [COLOR_W-1:0] pv_r;
  logic [AW-1:0]      clr_addr_r;

  logic               ymaj_r, dneg_r, mneg_r;
  logic [7:0]         n_r, maj_r, k_r;
  logic [QW-1:0]      q_r, qd_r;
  logic [7:0]         r_r, rd_r;
  logic [COUNT_W-1:0] cnt_r;

  logic               out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               div_start, div_done;
  logic [QW-1:0]      div_quot;
  logic [7:0]         div_rem;

  // setup terms
  logic [8:0] dx, dy;
  logic [7:0] adx, ady, n_s, dm_abs;
  logic       ymaj_s;

  // per-step terms
  logic [7:0]     ipos;
  logic [8:0]     minor_a, minor_b, col_a, row_a, col_b, row_b;
  logic           ok_a, ok_b, pix_ok, out_free;
  logic [AW-1:0]  addr_a, addr_b, addr_p;
  logic [FRAC_BITS:0] w_a, w_b;
  logic [8:0]     rsum;
  logic           carry;

  function automatic logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] old,
                                               input logic [COLOR_W-1:0] lin,
                                               input logic [FRAC_BITS:0] w);
    logic [FRAC_BITS+17:0] acc;
    logic [COLOR_W-1:0]    res;
    res = '0;
    for (int c = 0; c < 3; c++) begin
      acc = (FRAC_BITS+18)'(old[c*8 +: 8]) * (FRAC_BITS+18)'(ONE - w)
          + (FRAC_BITS+18)'(lin[c*8 +: 8]) * (FRAC_BITS+18)'(w);
      res[c*8 +: 8] = acc[FRAC_BITS +: 8];
    end
    return res;
  endfunction

  function automatic logic in_store(input logic [8:0] col, input logic [8:0] row);
    return (32'(col) < FB_WIDTH) && (32'(row) < FB_HEIGHT);
  endfunction

  function automatic logic [AW-1:0] pix_addr(input logic [8:0] col, input logic [8:0] row);
    return AW'((AW+9)'(row) * (AW+9)'(FB_WIDTH) + (AW+9)'(col));
  endfunction

  ald_div #(.DVW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({dm_abs, {FRAC_BITS{1'b0}}}),
    .divisor  (n_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // line geometry from the held command
  always_comb begin
    dx     = {1'b0, xe_r} - {1'b0, xs_r};
    dy     = {1'b0, ye_r} - {1'b0, ys_r};
    adx    = dx[8] ? 8'(-dx) : dx[7:0];
    ady    = dy[8] ? 8'(-dy) : dy[7:0];
    ymaj_s = ady > adx;
    n_s    = ymaj_s ? ady : adx;
    dm_abs = ymaj_s ? adx : ady;
  end

  // pixel pair of the current step
  always_comb begin
    ipos    = q_r[QW-1:FRAC_BITS];
    minor_b = {1'b0, ipos};
    minor_a = minor_b + 9'd1;
    col_a   = ymaj_r ? minor_a : {1'b0, maj_r};
    row_a   = ymaj_r ? {1'b0, maj_r} : minor_a;
    col_b   = ymaj_r ? minor_b : {1'b0, maj_r};
    row_b   = ymaj_r ? {1'b0, maj_r} : minor_b;
    ok_a    = in_store(col_a, row_a);
    ok_b    = in_store(col_b, row_b);
    addr_a  = pix_addr(col_a, row_a);
    addr_b  = pix_addr(col_b, row_b);
    w_a     = {1'b0, q_r[FRAC_BITS-1:0]};
    w_b     = ONE - w_a;
    pix_ok  = in_store({1'b0, xs_r}, {1'b0, ys_r});
    addr_p  = pix_addr({1'b0, xs_r}, {1'b0, ys_r});
    rsum    = {1'b0, r_r} + {1'b0, rd_r};
    carry   = rsum >= {1'b0, n_r};
    out_free = !out_valid_r || out_ch.ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (cmd_t'(in_ch.command))
            CMD_DRAW:  state_nxt = ST_SETUP;
            CMD_WRITE: state_nxt = ST_PWR;
            CMD_READ:  state_nxt = ST_PRD;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PWR:   state_nxt = ST_DONE;
      ST_PRD:   state_nxt = ST_DONE;
      ST_SETUP: state_nxt = (n_s == 8'd0) ? ST_DONE : ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_RDA;
      ST_RDA:   state_nxt = ST_WRA;
      ST_WRA:   state_nxt = ST_WRB;
      ST_WRB:   state_nxt = (k_r + 8'd1 == n_r) ? ST_DONE : ST_RDA;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // store port controls
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = addr_a;
    we        = 1'b0;
    wr_addr   = addr_a;
    wdata     = blend(rdata_r, line_color_r, w_a);
    div_start = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_addr_r;
        wdata   = '0;
      end
      ST_PWR: begin
        we      = pix_ok;
        wr_addr = addr_p;
        wdata   = pv_r;
      end
      ST_PRD: begin
        rd_en   = pix_ok;
        rd_addr = addr_p;
      end
      ST_SETUP: div_start = (n_s != 8'd0);
      ST_RDA:   rd_en = ok_a;
      ST_WRA: begin
        we      = ok_a;
        rd_en   = ok_b;
        rd_addr = addr_b;
      end
      ST_WRB: begin
        we      = ok_b;
        wr_addr = addr_b;
        wdata   = blend(rdata_r, line_color_r, w_b);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wdata;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      line_color_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (cfg_ch.valid) line_color_r <= cfg_ch.line_color;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cmd_r <= in_ch.command;
        xs_r  <= in_ch.x_start;
        ys_r  <= in_ch.y_start;
        xe_r  <= in_ch.x_end;
        ye_r  <= in_ch.y_end;
        pv_r  <= in_ch.pixel_value;
      end
      ST_SETUP: begin
        ymaj_r <= ymaj_s;
        n_r    <= n_s;
        dneg_r <= ymaj_s ? dy[8] : dx[8];
        mneg_r <= ymaj_s ? dx[8] : dy[8];
        maj_r  <= ymaj_s ? ys_r : xs_r;
        q_r    <= {(ymaj_s ? xs_r : ys_r), {FRAC_BITS{1'b0}}};
        r_r    <= '0;
        k_r    <= '0;
        cnt_r  <= '0;
      end
      ST_DIV: begin
        // floor division of the signed step increment
        if (mneg_r) begin
          qd_r <= QW'(-div_quot - QW'(div_rem != 8'd0));
          rd_r <= (div_rem != 8'd0) ? 8'(n_r - div_rem) : 8'd0;
        end else begin
          qd_r <= div_quot;
          rd_r <= div_rem;
        end
      end
      ST_WRA: cnt_r <= cnt_r + COUNT_W'(ok_a);
      ST_WRB: begin
        cnt_r <= cnt_r + COUNT_W'(ok_b);
        k_r   <= k_r + 8'd1;
        maj_r <= dneg_r ? maj_r - 8'd1 : maj_r + 8'd1;
        r_r   <= carry ? 8'(rsum - {1'b0, n_r}) : rsum[7:0];
        q_r   <= q_r + qd_r + QW'(carry);
      end
      default: ;
    endcase
  end

  // result word
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_color_r <= (cmd_t'(cmd_r) == CMD_READ && pix_ok) ? rdata_r : '0;
      out_count_r <= (cmd_t'(cmd_r) == CMD_DRAW) ? cnt_r : '0;
    end
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.read_color     = out_color_r;
  assign out_ch.pixels_written = out_count_r;

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ch.ready)
    else $error("command accepted during clear sweep");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == ST_CLEAR || state_r == ST_PWR || state_r == ST_WRA ||
            state_r == ST_WRB))
    else $error("store write outside a write state");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDA) |-> (r_r < n_r))
    else $error("step remainder out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && cmd_t'(cmd_r) == CMD_DRAW) |->
    (cnt_r <= {1'b0, n_r, 1'b0}))
    else $error("draw count exceeds two per step");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide wait");

endmodule
